/* src/text_terminal_scroll_cursor_unit_macros.svh */
// Assertion macros used by the terminal cursor unit checker.
`ifndef TEXT_TERMINAL_SCROLL_CURSOR_UNIT_MACROS_SVH
`define TEXT_TERMINAL_SCROLL_CURSOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSCU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSCU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/tscu_pkg.sv */
// Shared constants, codes and types of the terminal cursor unit.
package tscu_pkg;

	localparam int unsigned SCREEN_W = 640;
	localparam int unsigned SCREEN_H = 480;
	localparam int unsigned GLYPH_W  = 8;
	localparam int unsigned COLS     = SCREEN_W / GLYPH_W;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned COL_W   = 7;
	localparam int unsigned LINE_W  = 9;
	localparam int unsigned X_W     = 10;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned PROD_W  = 2 * LINE_W;
	localparam int unsigned TDATA_W = 56;

	localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [CODE_W-1:0] CHAR_FIRST = 8'd32;
	localparam logic [CODE_W-1:0] CHAR_LAST  = 8'd126;

	localparam logic [LINE_W-1:0] HEIGHT_RESET = 9'd16;
	localparam logic [LINE_W-1:0] SCREEN_H_L   = 9'(SCREEN_H);
	localparam logic [COL_W-1:0]  COLS_C       = 7'(COLS);

	// x mod 480: 480 = 32 * 15, so q = ((x >> 5) * 8739) >> 17 is exact for x < 2^18
	localparam logic [13:0] DIV15_MULT  = 14'd8739;
	localparam int unsigned DIV15_SHIFT = 17;

	typedef enum logic [KIND_W-1:0] {
		KIND_GLYPH  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_INIT = 1'b1
	} op_t;

	// Cursor snapshot taken when an item is accepted
	typedef struct packed {
		logic              has_a;    // scroll or clear-screen result
		logic              is_init;
		logic              has_g;    // glyph result
		logic [CODE_W-1:0] code;
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] row;
		logic [LINE_W-1:0] height;
		logic [LINE_W-1:0] base;
		logic [LINE_W-1:0] bottom;
	} cur_snap_t;

endpackage

/* src/tscu_cursor.sv */
// Cursor and scroll state tracker of the terminal cursor unit.
module tscu_cursor import tscu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              opcode,
	input  logic [CODE_W-1:0] char_code,
	input  logic [LINE_W-1:0] height,
	output cur_snap_t         snap
);

	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] row_q;
	logic [LINE_W-1:0] base_q;
	logic [LINE_W-1:0] hinit_q;   // glyph height latched at init
	logic [LINE_W-1:0] rowext_q;  // (row + 1) * hinit

	logic              is_init;
	logic              is_nl;
	logic              wrap;
	logic              scroll_hit;
	logic              print;
	logic [LINE_W:0]   ext_sum;
	logic [LINE_W:0]   base_sum;
	logic [LINE_W-1:0] base_adv;
	logic [COL_W-1:0]  col_mid;
	logic [COL_W-1:0]  col_n;
	logic [LINE_W-1:0] row_n;
	logic [LINE_W-1:0] rowext_n;
	logic [LINE_W-1:0] base_n;

	always_comb begin
		is_init    = (opcode == OP_INIT);
		is_nl      = (char_code == CHAR_CR) || (char_code == CHAR_LF);
		wrap       = is_nl || (col_q >= COLS_C);
		ext_sum    = {1'b0, rowext_q} + {1'b0, hinit_q};
		// next row would fall below the bottom row
		scroll_hit = wrap && (ext_sum > {1'b0, SCREEN_H_L});
		base_sum   = {1'b0, base_q} + {1'b0, height};
		base_adv   = (base_sum >= {1'b0, SCREEN_H_L}) ?
			LINE_W'(base_sum - {1'b0, SCREEN_H_L}) : base_sum[LINE_W-1:0];
		print      = !is_nl && (char_code >= CHAR_FIRST) && (char_code <= CHAR_LAST);
		col_mid    = wrap ? '0 : col_q;
		col_n      = print ? col_mid + 7'd1 : col_mid;
		row_n      = (wrap && !scroll_hit) ? row_q + 9'd1 : row_q;
		rowext_n   = (wrap && !scroll_hit) ? ext_sum[LINE_W-1:0] : rowext_q;
		base_n     = scroll_hit ? base_adv : base_q;

		snap.has_a   = is_init || scroll_hit;
		snap.is_init = is_init;
		snap.has_g   = !is_init && print;
		snap.code    = char_code;
		snap.col     = col_mid;
		snap.row     = row_n;
		snap.height  = height;
		snap.base    = is_init ? '0 : base_n;
		snap.bottom  = rowext_q - hinit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
			hinit_q  <= HEIGHT_RESET;
			rowext_q <= HEIGHT_RESET;
		end else if (accept) begin
			if (is_init) begin
				col_q    <= '0;
				row_q    <= '0;
				base_q   <= '0;
				hinit_q  <= height;
				rowext_q <= height;
			end else begin
				col_q    <= col_n;
				row_q    <= row_n;
				base_q   <= base_n;
				rowext_q <= rowext_n;
			end
		end
	end

endmodule

/* src/text_terminal_scroll_cursor_unit.sv */
// Top level of the text terminal cursor unit with hardware scroll.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: char_code; s_tuser: opcode
//  m_       out  m_tvalid/m_tready  m_tdata: draw/scroll/clear fields; m_tuser: kind; m_tlast
//  cfg_     in   cfg_we             cfg_wdata: glyph height
//
// One item is accepted per cycle while s_tready is high; the cursor state is updated in the accepting cycle.
// The result is registered through stages s1 to s5 (row * height, mod-480 reduction),
// and m_tvalid is driven by the valid of the last stage.
// An item giving scroll plus glyph holds the output stage until both results are taken,
// so the sustained rate is set by the single output register.
// arst_n clears cursor, scroll base and stage valids; glyph height resets to 16.
// A stalled m_tready backs up the stages; s_tready drops only when all are full.
module text_terminal_scroll_cursor_unit import tscu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CODE_W-1:0]  s_tdata,   // [7:0] char_code
	input  logic               s_tuser,   // [0] opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [7:0] glyph_code, [17:8] pos_x, [26:18] pos_y,
	                                      // [35:27] scroll_offset, [44:36] clear_y,
	                                      // [53:45] clear_height, [55:54] zero
	output logic [KIND_W-1:0]  m_tuser,   // [1:0] kind
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic [LINE_W-1:0]  cfg_wdata
);

	// Per-result payload carried down the stages
	typedef struct packed {
		logic              has_a;
		logic              is_init;
		logic              has_g;
		logic [CODE_W-1:0] code;
		logic [X_W-1:0]    px;
		logic [LINE_W-1:0] base;
		logic [LINE_W-1:0] cy;
		logic [LINE_W-1:0] height;
	} res_t;

	logic [LINE_W-1:0] glyph_height_q;
	logic [LINE_W-1:0] h_eff;
	logic              accept;
	cur_snap_t         snap;

	cur_snap_t         snap_s1;
	res_t              res_s2, res_s3, res_s4, res_s5;
	logic [PROD_W-1:0] prod_s2, prod_s3;
	logic [26:0]       qm_s3;
	logic [LINE_W-1:0] r_s4;
	logic [LINE_W-1:0] py_s5;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              a_pend_q;
	logic              en1, en2, en3, en4, en5;
	logic              out_last;
	logic              out_done;

	// stage 1 logic
	logic [LINE_W:0]   cy_sum;
	res_t              res_n2;
	logic [PROD_W-1:0] prod_n2;
	// stage 2..4 logic
	logic [26:0]       qm_n3;
	logic [LINE_W-1:0] q_n4;
	logic [PROD_W-1:0] r_full;
	logic [LINE_W:0]   py_sum;
	logic [LINE_W-1:0] py_n5;
	// output fields
	kind_t             kind_o;
	logic [CODE_W-1:0] code_o;
	logic [X_W-1:0]    px_o;
	logic [LINE_W-1:0] py_o, so_o, cy_o, ch_o;

	// Configuration register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			glyph_height_q <= cfg_wdata;
		end
	end

	// Zero acts as one, anything above the screen height acts as the screen height
	always_comb begin
		if (glyph_height_q == '0) begin
			h_eff = 9'd1;
		end else if (glyph_height_q > SCREEN_H_L) begin
			h_eff = SCREEN_H_L;
		end else begin
			h_eff = glyph_height_q;
		end
	end

	// Stall chain: a stage loads when it is empty or its content moves on
	always_comb begin
		out_last = !(a_pend_q && res_s5.has_g);
		out_done = v_s5 && m_tready && out_last;
		en5      = !v_s5 || out_done;
		en4      = !v_s4 || en5;
		en3      = !v_s3 || en4;
		en2      = !v_s2 || en3;
		en1      = !v_s1 || en2;
	end

	assign s_tready = en1;
	assign accept   = s_tvalid && s_tready;

	tscu_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (s_tuser),
		.char_code (s_tdata),
		.height    (h_eff),
		.snap      (snap)
	);

	// Stage 1 -> 2: clear band start, glyph x, row times height
	always_comb begin
		cy_sum         = {1'b0, snap_s1.base} + {1'b0, snap_s1.bottom};
		res_n2.has_a   = snap_s1.has_a;
		res_n2.is_init = snap_s1.is_init;
		res_n2.has_g   = snap_s1.has_g;
		res_n2.code    = snap_s1.code;
		res_n2.px      = X_W'(snap_s1.col) * X_W'(GLYPH_W);
		res_n2.base    = snap_s1.base;
		res_n2.cy      = (cy_sum >= {1'b0, SCREEN_H_L}) ?
			LINE_W'(cy_sum - {1'b0, SCREEN_H_L}) : cy_sum[LINE_W-1:0];
		res_n2.height  = snap_s1.height;
		prod_n2        = PROD_W'(snap_s1.row) * PROD_W'(snap_s1.height);
	end

	// Stages 2..4: reduce row * height mod 480 and add the scroll base
	always_comb begin
		qm_n3  = 27'(prod_s2[PROD_W-1:5]) * 27'(DIV15_MULT);
		q_n4   = qm_s3[DIV15_SHIFT +: LINE_W];
		r_full = prod_s3 - PROD_W'(q_n4) * PROD_W'(SCREEN_H);
		py_sum = {1'b0, res_s4.base} + {1'b0, r_s4};
		py_n5  = (py_sum >= {1'b0, SCREEN_H_L}) ?
			LINE_W'(py_sum - {1'b0, SCREEN_H_L}) : py_sum[LINE_W-1:0];
	end

	// Stage valids and the pending-first-result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			a_pend_q <= 1'b0;
		end else begin
			// drop items that cause no result right at the entry
			if (en1) v_s1 <= accept && (snap.has_a || snap.has_g);
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) begin
				v_s5     <= v_s4;
				a_pend_q <= v_s4 && res_s4.has_a;
			end else if (m_tready) begin
				// first of two results taken, glyph goes next
				a_pend_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (en1 && accept) snap_s1 <= snap;
		if (en2 && v_s1) begin
			res_s2  <= res_n2;
			prod_s2 <= prod_n2;
		end
		if (en3 && v_s2) begin
			res_s3  <= res_s2;
			prod_s3 <= prod_s2;
			qm_s3   <= qm_n3;
		end
		if (en4 && v_s3) begin
			res_s4 <= res_s3;
			r_s4   <= r_full[LINE_W-1:0];
		end
		if (en5 && v_s4) begin
			res_s5 <= res_s4;
			py_s5  <= py_n5;
		end
	end

	// Output select: scroll or clear first, then the glyph
	always_comb begin
		kind_o = KIND_GLYPH;
		code_o = '0;
		px_o   = '0;
		py_o   = '0;
		so_o   = '0;
		cy_o   = '0;
		ch_o   = '0;
		priority if (a_pend_q && res_s5.is_init) begin
			kind_o = KIND_CLEAR;
			ch_o   = SCREEN_H_L;
		end else if (a_pend_q) begin
			kind_o = KIND_SCROLL;
			so_o   = res_s5.base;
			cy_o   = res_s5.cy;
			ch_o   = res_s5.height;
		end else begin
			kind_o = KIND_GLYPH;
			code_o = res_s5.code;
			px_o   = res_s5.px;
			py_o   = py_s5;
			so_o   = res_s5.base;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tlast  = out_last;
	assign m_tuser  = kind_o;
	assign m_tdata  = {2'b00, ch_o, cy_o, so_o, py_o, px_o, code_o};

endmodule

/* src/tscu_checker.sv */
// Port-level assertion checker of the terminal cursor unit, bound to the top level.
`include "text_terminal_scroll_cursor_unit_macros.svh"

module tscu_checker import tscu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]  m_tuser,
	input logic               m_tlast
);

	// a glyph is always printable and always the final result of its character
	`TSCU_ASSERT_IMP(a_glyph_printable, clk, arst_n, m_tvalid && m_tuser == KIND_GLYPH, m_tlast && m_tdata[7:0] >= CHAR_FIRST && m_tdata[7:0] <= CHAR_LAST && m_tdata[53:45] == 9'd0, "glyph result malformed")

	// clear-screen stands alone and covers the full height
	`TSCU_ASSERT_IMP(a_clear_full, clk, arst_n, m_tvalid && m_tuser == KIND_CLEAR, m_tlast && m_tdata[53:45] == SCREEN_H_L && m_tdata[35:0] == 36'd0, "clear-screen result malformed")

	// a scroll that is not last is followed by its glyph
	`TSCU_ASSERT_NXT(a_scroll_then_glyph, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == KIND_GLYPH && m_tlast, "glyph missing after scroll")

	// stalled result holds
	`TSCU_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind text_terminal_scroll_cursor_unit tscu_checker u_tscu_checker (.*);

/* dv/text_terminal_scroll_cursor_unit_test.sv */
// Self-checking testbench of the text terminal cursor unit with hardware scroll.
module text_terminal_scroll_cursor_unit_test;
	import tscu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;   // covers the pipeline plus holds
	localparam int unsigned PHASE_ITEMS  = 150;

	// One character or init command waiting to be sent
	typedef struct {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic              hold;   // wait until every pending result has arrived
	} term_input_t;

	// One expected draw, scroll or clear command
	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] glyph;
		logic [X_W-1:0]    pos_x;
		logic [LINE_W-1:0] pos_y;
		logic [LINE_W-1:0] scroll_offset;
		logic [LINE_W-1:0] clear_y;
		logic [LINE_W-1:0] clear_height;
		logic              last;
	} draw_cmd_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [CODE_W-1:0]  s_tdata   = '0;
	logic               s_tuser   = 1'b0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]  m_tuser;
	logic               m_tlast;
	logic               cfg_we    = 1'b0;
	logic [LINE_W-1:0]  cfg_wdata = '0;

	// Terminal state as the predictor sees it
	logic [LINE_W-1:0] glyph_height   = HEIGHT_RESET;
	logic [COL_W-1:0]  cur_col        = '0;
	logic [LINE_W-1:0] cur_row        = '0;
	logic [LINE_W-1:0] scroll_base    = '0;
	logic [LINE_W-1:0] rows_on_screen = 9'(SCREEN_H / 16);
	logic [LINE_W-1:0] bottom_line    = 9'((SCREEN_H / 16 - 1) * 16);

	term_input_t pending_chars [$];
	draw_cmd_t   expected_cmds [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_queued   = 0;
	int unsigned items_accepted = 0;
	int unsigned mismatch_count = 0;
	int unsigned cmds_checked   = 0;
	int unsigned kind_seen [3]  = '{0, 0, 0};
	int unsigned height_writes  = 0;
	int unsigned cycle_count    = 0;

	text_terminal_scroll_cursor_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Advance the cursor for one accepted transaction and queue the commands it causes.
	task automatic advance_cursor(input op_t op, input logic [CODE_W-1:0] code);
		draw_cmd_t   cmds [2];
		int unsigned h;
		int          n;
		logic        newline;
		// Zero height acts as one; anything past the screen acts as one full-screen row
		h = (glyph_height == 0) ? 1 : (glyph_height > SCREEN_H) ? SCREEN_H : glyph_height;
		n = 0;
		cmds[0] = '0;
		cmds[1] = '0;
		if (op == OP_INIT) begin
			rows_on_screen       = 9'(SCREEN_H / h);
			bottom_line          = 9'((rows_on_screen - 1) * h);
			cur_col              = '0;
			cur_row              = '0;
			scroll_base          = '0;
			cmds[0].kind         = KIND_CLEAR;
			cmds[0].clear_height = SCREEN_H_L;
			n                    = 1;
		end else begin
			newline = (code == CHAR_CR) || (code == CHAR_LF);
			// A new line, or any character hitting a full line, opens the next row
			if (newline || cur_col >= COLS_C) begin
				cur_col = '0;
				cur_row = cur_row + 1'b1;
				if (cur_row >= rows_on_screen) begin
					// Past the bottom: roll the scroll offset and blank the exposed band
					scroll_base           = 9'((scroll_base + h) % SCREEN_H);
					cmds[0].kind          = KIND_SCROLL;
					cmds[0].scroll_offset = scroll_base;
					cmds[0].clear_y       = 9'((scroll_base + bottom_line) % SCREEN_H);
					cmds[0].clear_height  = 9'(h);
					n                     = 1;
					cur_row               = rows_on_screen - 1'b1;
				end
			end
			// Only printable codes draw; other bytes at most wrap the line
			if (!newline && code >= CHAR_FIRST && code <= CHAR_LAST) begin
				cmds[n].kind          = KIND_GLYPH;
				cmds[n].glyph         = code;
				cmds[n].pos_x         = 10'(cur_col * GLYPH_W);
				cmds[n].pos_y         = 9'((scroll_base + cur_row * h) % SCREEN_H);
				cmds[n].scroll_offset = scroll_base;
				n++;
				cur_col = cur_col + 1'b1;
			end
		end
		if (n > 0)
			cmds[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_cmds.push_back(cmds[i]);
	endtask

	task automatic check_field(input string name, input logic [X_W-1:0] want,
			input logic [X_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Sender: present queued transactions, idling at random and holding flagged items
	// until the output side has drained.
	always @(posedge clk) begin : drive_chars
		term_input_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_cursor(op_t'(s_tuser), s_tdata);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_chars.size() != 0 &&
						(!pending_chars[0].hold || expected_cmds.size() == 0) &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_chars.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.code;
					s_tuser  <= nxt.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall at random and compare every output transaction with the oldest
	// expected command.
	always @(posedge clk) begin : watch_cmds
		draw_cmd_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (expected_cmds.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected output transaction, kind %0d tdata %h last %b",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					want = expected_cmds.pop_front();
					cmds_checked++;
					kind_seen[want.kind]++;
					check_field("kind",          X_W'(want.kind),  X_W'(m_tuser));
					check_field("glyph_code",    X_W'(want.glyph), X_W'(m_tdata[7:0]));
					check_field("pos_x",         want.pos_x,       m_tdata[17:8]);
					check_field("pos_y",         X_W'(want.pos_y), X_W'(m_tdata[26:18]));
					check_field("scroll_offset", X_W'(want.scroll_offset),
						X_W'(m_tdata[35:27]));
					check_field("clear_y",       X_W'(want.clear_y), X_W'(m_tdata[44:36]));
					check_field("clear_height",  X_W'(want.clear_height),
						X_W'(m_tdata[53:45]));
					check_field("last",          X_W'(want.last),  X_W'(m_tlast));
				end
			end
		end
	end

	// Watchdog: end the run if it takes far longer than any correct run could
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_terminal_scroll_cursor_unit test failed");
		$finish;
	end

	task automatic queue_item(input op_t op, input logic [CODE_W-1:0] code, input logic hold);
		pending_chars.push_back('{op: op, code: code, hold: hold});
		items_queued++;
	endtask

	// Wait until every transaction is accepted and answered, then let in-flight
	// no-result items leave the pipeline.
	task automatic settle();
		while (items_accepted != items_queued || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write glyph height; only called while the block is idle
	task automatic write_height(input logic [LINE_W-1:0] value);
		@(posedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= value;
		glyph_height  = value;
		height_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Queue one line of text: mostly printable, sometimes long enough to wrap,
	// with noise bytes, the odd init and a varied line ending.
	task automatic queue_line();
		int unsigned len;
		logic [CODE_W-1:0] ch;
		if ($urandom_range(0, 49) == 0)
			queue_item(OP_INIT, 8'($urandom_range(0, 255)), 1'b0);
		len = ($urandom_range(0, 2) == 0) ? $urandom_range(70, 175) : $urandom_range(0, 40);
		for (int unsigned i = 0; i < len; i++) begin
			ch = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(32, 126));
			queue_item(OP_PUT, ch, i == 0 && $urandom_range(0, 29) == 0);
		end
		case ($urandom_range(0, 5))
			0: begin
				queue_item(OP_PUT, CHAR_CR, 1'b0);
				queue_item(OP_PUT, CHAR_LF, 1'b0);
			end
			1, 2:    queue_item(OP_PUT, CHAR_CR, 1'b0);
			3:       queue_item(OP_PUT, CHAR_LF, 1'b0);
			4:       ;   // run straight into the next line
			default: queue_item(OP_PUT, 8'($urandom_range(0, 255)), 1'b0);
		endcase
	endtask

	initial begin
		logic [LINE_W-1:0] phase_heights [8];
		int unsigned       phase_start;
		phase_heights = '{9'd16, 9'd100, 9'd480, 9'd1, 9'd511, 9'd0, 9'd37, 9'd16};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: printable edges, non-printable bytes, both new lines.
		// The zero byte waits for the output side to drain first.
		queue_item(OP_PUT, 8'h41, 1'b0);
		queue_item(OP_PUT, CHAR_FIRST, 1'b0);
		queue_item(OP_PUT, CHAR_LAST, 1'b0);
		queue_item(OP_PUT, 8'h00, 1'b1);
		queue_item(OP_PUT, 8'hFF, 1'b0);
		queue_item(OP_PUT, 8'h1F, 1'b0);
		queue_item(OP_PUT, 8'h7F, 1'b0);
		queue_item(OP_PUT, CHAR_CR, 1'b0);
		queue_item(OP_PUT, CHAR_LF, 1'b0);
		queue_item(OP_PUT, 8'h7A, 1'b0);
		settle();

		// One full-screen row: every new line scrolls
		write_height(SCREEN_H_L);
		queue_item(OP_INIT, 8'h00, 1'b0);
		queue_item(OP_PUT, CHAR_CR, 1'b0);
		queue_item(OP_PUT, 8'h42, 1'b0);
		queue_item(OP_PUT, CHAR_LF, 1'b0);
		queue_item(OP_PUT, 8'hC8, 1'b0);
		queue_item(OP_INIT, 8'hFF, 1'b0);
		settle();

		// Zero height behaves as one line per row
		write_height('0);
		queue_item(OP_INIT, 8'h5A, 1'b0);
		queue_item(OP_PUT, 8'h43, 1'b0);
		queue_item(OP_PUT, CHAR_CR, 1'b0);
		settle();

		// Oversized height clamps to the screen
		write_height('1);
		queue_item(OP_INIT, 8'hA5, 1'b0);
		queue_item(OP_PUT, CHAR_LAST, 1'b0);
		queue_item(OP_PUT, CHAR_LF, 1'b0);
		settle();

		// Random phases: cycle the pacing mode and the glyph height; skip init at
		// random so the old row count meets a new height.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			write_height(p == 7 ? 9'($urandom_range(0, 511)) : phase_heights[p]);
			if ($urandom_range(0, 1) == 0)
				queue_item(OP_INIT, 8'($urandom_range(0, 255)), 1'b0);
			phase_start = items_queued;
			while (items_queued - phase_start < PHASE_ITEMS)
				queue_line();
			settle();
		end

		$display("Sent %0d character and init transactions over %0d glyph height settings,",
			items_accepted, height_writes);
		$display("checked %0d commands: %0d glyph draws, %0d scrolls, %0d screen clears.",
			cmds_checked, kind_seen[KIND_GLYPH], kind_seen[KIND_SCROLL], kind_seen[KIND_CLEAR]);
		if (mismatch_count == 0) begin
			$display("text_terminal_scroll_cursor_unit test passed");
		end else begin
			$display("text_terminal_scroll_cursor_unit test failed");
		end
		$finish;
	end

endmodule
